[rtl/sbi_pkg.sv]
package sbi_pkg;

  // Sign of a difference of two products, taken apart into two flags.
  // Positive is neither neg nor zero.
  typedef struct packed {
    logic neg;
    logic zero;
  } sign_t;

endpackage

[rtl/sbi_sdiff.sv]
module sbi_sdiff #(
  parameter int W = 17
) (
  input  logic signed [W-1:0] a,
  input  logic signed [W-1:0] b,
  input  logic signed [W-1:0] c,
  input  logic signed [W-1:0] d,
  output sbi_pkg::sign_t      sgn
);

  logic signed [2*W-1:0] p;
  logic signed [2*W-1:0] q;
  logic        [2*W:0]   r;

  // Exact products at full width; one extra bit keeps the difference exact.
  assign p = a * b;
  assign q = c * d;
  assign r = {p[2*W-1], p} - {q[2*W-1], q};

  assign sgn.neg  = r[2*W];
  assign sgn.zero = (r == '0);

endmodule

[rtl/sbi_edge.sv]
module sbi_edge #(
  parameter int CW = 16
) (
  input  logic signed [CW-1:0] x0,
  input  logic signed [CW-1:0] y0,
  input  logic signed [CW-1:0] x1,
  input  logic signed [CW-1:0] y1,
  input  logic signed [CW-1:0] bx,
  input  logic signed [CW-1:0] ex,
  input  logic signed [CW-1:0] yv,
  output logic                 hit
);

  logic signed [CW:0]   dx;
  logic signed [CW:0]   dy;
  logic signed [CW:0]   bx_d;
  logic signed [CW:0]   ex_d;
  logic signed [CW:0]   yv_d;
  logic signed [CW-1:0] seg_lo;
  logic signed [CW-1:0] seg_hi;
  logic signed [CW-1:0] edg_lo;
  logic signed [CW-1:0] edg_hi;
  logic signed [CW-1:0] ov_lo;
  logic signed [CW-1:0] ov_hi;
  logic                 off_side;
  logic                 overlap;
  sbi_pkg::sign_t       sb;
  sbi_pkg::sign_t       se;
  logic                 sb_pos;
  logic                 se_pos;

  assign dx   = {x1[CW-1], x1} - {x0[CW-1], x0};
  assign dy   = {y1[CW-1], y1} - {y0[CW-1], y0};
  assign bx_d = {bx[CW-1], bx} - {x0[CW-1], x0};
  assign ex_d = {ex[CW-1], ex} - {x0[CW-1], x0};
  assign yv_d = {yv[CW-1], yv} - {y0[CW-1], y0};

  sbi_sdiff #(.W(CW + 1)) u_sb (.a(bx_d), .b(dy), .c(yv_d), .d(dx), .sgn(sb));
  sbi_sdiff #(.W(CW + 1)) u_se (.a(ex_d), .b(dy), .c(yv_d), .d(dx), .sgn(se));

  always_comb begin
    seg_lo = (x0 < x1) ? x0 : x1;
    seg_hi = (x0 > x1) ? x0 : x1;
    edg_lo = (bx < ex) ? bx : ex;
    edg_hi = (bx > ex) ? bx : ex;
    ov_lo  = (seg_lo > edg_lo) ? seg_lo : edg_lo;
    ov_hi  = (seg_hi < edg_hi) ? seg_hi : edg_hi;
  end

  assign off_side = (y0 > yv && y1 > yv) || (y0 < yv && y1 < yv);
  assign overlap  = (ov_lo <= ov_hi);
  assign sb_pos   = !sb.neg && !sb.zero;
  assign se_pos   = !se.neg && !se.zero;

  always_comb begin
    if (off_side) begin
      hit = 1'b0;
    end else if (dy == '0) begin
      hit = overlap;
    end else begin
      hit = !((sb_pos && se_pos) || (sb.neg && se.neg));
    end
  end

endmodule

[rtl/segment_box_intersect_test.sv]
// Segment versus axis-aligned box test. Each transaction carries a segment
// (start and end point) and a box (low and high corner) as signed
// COORD_BITS-wide coordinates; the block answers out_hit = 1 when the closed
// segment touches or crosses the closed box. A transaction is taken at every
// clock edge where start is high and busy is low; busy is always low, so a
// new transaction may be issued in every cycle. The result shows on out_hit
// with out_valid high for exactly one cycle, after the transaction has gone
// through the input register and the test logic into the result register.
// Results come out in issue order, one per transaction. The receiver cannot
// stall the block and must take each result in its cycle. Throughput is one
// transaction per cycle; the critical path is one (COORD_BITS+1)-square
// multiply followed by a subtract and zero test.
// An unordered box (low above high) is tested by the same comparisons.
module segment_box_intersect_test #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] in_seg_start_x,
  input  logic signed [COORD_BITS-1:0] in_seg_start_y,
  input  logic signed [COORD_BITS-1:0] in_seg_end_x,
  input  logic signed [COORD_BITS-1:0] in_seg_end_y,
  input  logic signed [COORD_BITS-1:0] in_box_low_x,
  input  logic signed [COORD_BITS-1:0] in_box_low_y,
  input  logic signed [COORD_BITS-1:0] in_box_high_x,
  input  logic signed [COORD_BITS-1:0] in_box_high_y,
  output logic                         out_valid,
  output logic                         out_hit
);

  // Input register: control bit is reset, payload is not.
  logic                         in_valid_r;
  logic signed [COORD_BITS-1:0] bx_r;
  logic signed [COORD_BITS-1:0] by_r;
  logic signed [COORD_BITS-1:0] ex_r;
  logic signed [COORD_BITS-1:0] ey_r;
  logic signed [COORD_BITS-1:0] xl_r;
  logic signed [COORD_BITS-1:0] yl_r;
  logic signed [COORD_BITS-1:0] xh_r;
  logic signed [COORD_BITS-1:0] yh_r;

  // Result register.
  logic out_valid_r;
  logic out_hit_r;
  logic out_hit_nxt;

  logic accept;
  logic reject;
  logic start_in;
  logic end_in;
  logic hit_bot;
  logic hit_top;
  logic hit_lft;
  logic hit_rgt;

  // The pipeline never holds off a transaction.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= accept;
    end
  end

  // Capture the payload on every accepted transaction; hold otherwise.
  always_ff @(posedge clk) begin
    if (accept) begin
      bx_r <= in_seg_start_x;
      by_r <= in_seg_start_y;
      ex_r <= in_seg_end_x;
      ey_r <= in_seg_end_y;
      xl_r <= in_box_low_x;
      yl_r <= in_box_low_y;
      xh_r <= in_box_high_x;
      yh_r <= in_box_high_y;
    end
  end

  // Drop segments lying wholly beyond one side of the box.
  assign reject = (bx_r > xh_r && ex_r > xh_r) || (bx_r < xl_r && ex_r < xl_r) ||
                  (by_r > yh_r && ey_r > yh_r) || (by_r < yl_r && ey_r < yl_r);

  // Accept when either endpoint lies inside the closed box.
  assign start_in = (xl_r <= bx_r) && (bx_r <= xh_r) && (yl_r <= by_r) && (by_r <= yh_r);
  assign end_in   = (xl_r <= ex_r) && (ex_r <= xh_r) && (yl_r <= ey_r) && (ey_r <= yh_r);

  // Edge tests, one per box side. Vertical edges reuse the same unit with x and y swapped.
  sbi_edge #(.CW(COORD_BITS)) u_bot (
    .x0(bx_r), .y0(by_r), .x1(ex_r), .y1(ey_r),
    .bx(xl_r), .ex(xh_r), .yv(yl_r), .hit(hit_bot)
  );

  sbi_edge #(.CW(COORD_BITS)) u_top (
    .x0(bx_r), .y0(by_r), .x1(ex_r), .y1(ey_r),
    .bx(xl_r), .ex(xh_r), .yv(yh_r), .hit(hit_top)
  );

  sbi_edge #(.CW(COORD_BITS)) u_lft (
    .x0(by_r), .y0(bx_r), .x1(ey_r), .y1(ex_r),
    .bx(yl_r), .ex(yh_r), .yv(xl_r), .hit(hit_lft)
  );

  sbi_edge #(.CW(COORD_BITS)) u_rgt (
    .x0(by_r), .y0(bx_r), .x1(ey_r), .y1(ex_r),
    .bx(yl_r), .ex(yh_r), .yv(xh_r), .hit(hit_rgt)
  );

  always_comb begin
    if (reject) begin
      out_hit_nxt = 1'b0;
    end else if (start_in || end_in) begin
      out_hit_nxt = 1'b1;
    end else begin
      out_hit_nxt = hit_bot || hit_top || hit_lft || hit_rgt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    out_hit_r <= out_hit_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_hit   = out_hit_r;

  // Every accepted transaction yields a strobe once it has passed the input and result registers.
  a_accept_to_result : assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> ##1 out_valid)
    else $error("accepted transaction produced no result strobe");

  // No strobe without a transaction in the input register the cycle before.
  a_no_spurious : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_valid_r))
    else $error("result strobe without a captured transaction");

  // A rejected segment never reports a hit.
  a_reject_miss : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && reject) |=> !out_hit)
    else $error("rejected segment reported as hit");

  // An endpoint inside the box always reports a hit unless rejected.
  a_inside_hit : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !reject && (start_in || end_in)) |=> out_hit)
    else $error("endpoint inside box not reported as hit");

endmodule

[verif/segment_box_checker.sv]
// Watches the transaction and result channels of the segment/box test,
// predicts out_hit for every accepted transaction and compares in order.
module segment_box_checker #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic                         busy,
  input  logic signed [COORD_BITS-1:0] in_seg_start_x,
  input  logic signed [COORD_BITS-1:0] in_seg_start_y,
  input  logic signed [COORD_BITS-1:0] in_seg_end_x,
  input  logic signed [COORD_BITS-1:0] in_seg_end_y,
  input  logic signed [COORD_BITS-1:0] in_box_low_x,
  input  logic signed [COORD_BITS-1:0] in_box_low_y,
  input  logic signed [COORD_BITS-1:0] in_box_high_x,
  input  logic signed [COORD_BITS-1:0] in_box_high_y,
  input  logic                         out_valid,
  input  logic                         out_hit,
  output int                           fail_count,
  output int                           pending
);

  // Differences of two coordinates need one bit more; keep two for margin.
  localparam int SW = COORD_BITS + 2;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [SW-1:0]         span_t;
  typedef logic signed [2*SW+1:0]       area_t;

  logic hit_queue[$];
  int   fails = 0;
  int   depth = 0;

  assign fail_count = fails;
  assign pending    = depth;

  function automatic span_t lesser(span_t a, span_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic span_t greater(span_t a, span_t b);
    return (a > b) ? a : b;
  endfunction

  // Sign of a*b - c*d, formed at full width.
  function automatic int cross_sign(span_t a, span_t b, span_t c, span_t d);
    area_t diff;
    diff = area_t'(a) * area_t'(b) - area_t'(c) * area_t'(d);
    if (diff < 0) return -1;
    if (diff == 0) return 0;
    return 1;
  endfunction

  // Segment (x0,y0)-(x1,y1) against the side from (lo,line) to (hi,line).
  function automatic bit side_met(span_t x0, span_t y0, span_t x1, span_t y1,
                                  span_t lo, span_t hi, span_t line);
    span_t dx;
    span_t dy;
    int    s_lo;
    int    s_hi;
    dx = x1 - x0;
    dy = y1 - y0;
    if (y0 > line && y1 > line) return 1'b0;
    if (y0 < line && y1 < line) return 1'b0;
    // Segment lies on the side's line: overlap of the two intervals.
    if (dy == 0)
      return greater(lesser(x0, x1), lesser(lo, hi)) <=
             lesser(greater(x0, x1), greater(lo, hi));
    s_lo = cross_sign(lo - x0, dy, line - y0, dx);
    s_hi = cross_sign(hi - x0, dy, line - y0, dx);
    if (s_lo > 0 && s_hi > 0) return 1'b0;
    if (s_lo < 0 && s_hi < 0) return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic predict_hit(coord_t sx_in, coord_t sy_in,
                                       coord_t ex_in, coord_t ey_in,
                                       coord_t lx_in, coord_t ly_in,
                                       coord_t hx_in, coord_t hy_in);
    span_t sx, sy, ex, ey, lx, ly, hx, hy;
    sx = sx_in; sy = sy_in; ex = ex_in; ey = ey_in;
    lx = lx_in; ly = ly_in; hx = hx_in; hy = hy_in;
    if ((sx > hx && ex > hx) || (sx < lx && ex < lx) ||
        (sy > hy && ey > hy) || (sy < ly && ey < ly))
      return 1'b0;
    if ((lx <= sx && sx <= hx && ly <= sy && sy <= hy) ||
        (lx <= ex && ex <= hx && ly <= ey && ey <= hy))
      return 1'b1;
    return side_met(sx, sy, ex, ey, lx, hx, ly) ||
           side_met(sx, sy, ex, ey, lx, hx, hy) ||
           side_met(sy, sx, ey, ex, ly, hy, lx) ||
           side_met(sy, sx, ey, ex, ly, hy, hx);
  endfunction

  always @(posedge clk) begin
    logic want;
    if (!rst_n) begin
      hit_queue.delete();
    end else begin
      if (out_valid) begin
        if (hit_queue.size() == 0) begin
          $error("out_hit %0d arrived with no transaction outstanding", out_hit);
          fails++;
        end else begin
          want = hit_queue.pop_front();
          if (out_hit !== want) begin
            $error("hit mismatch: expected %0d, actual %0d", want, out_hit);
            fails++;
          end
        end
      end
      if (start && !busy)
        hit_queue.push_back(predict_hit(in_seg_start_x, in_seg_start_y,
                                        in_seg_end_x, in_seg_end_y,
                                        in_box_low_x, in_box_low_y,
                                        in_box_high_x, in_box_high_y));
    end
    depth = hit_queue.size();
  end

endmodule

[verif/segment_box_intersect_test_test.sv]
// Stimulus and verdict for the segment/box test; the comparison against predicted
// results lives in segment_box_checker beside the block.
module segment_box_intersect_test_test;

  localparam int CB           = 16;
  localparam int RANDOM_ITEMS = 1280;
  // Random items in this window run back to back with no idle cycles.
  localparam int CALM_FIRST   = 500;
  localparam int CALM_LAST    = 800;

  typedef logic signed [CB-1:0] coord_t;

  logic   clk;
  logic   rst_n;
  logic   start;
  logic   busy;
  coord_t in_seg_start_x;
  coord_t in_seg_start_y;
  coord_t in_seg_end_x;
  coord_t in_seg_end_y;
  coord_t in_box_low_x;
  coord_t in_box_low_y;
  coord_t in_box_high_x;
  coord_t in_box_high_y;
  logic   out_valid;
  logic   out_hit;
  int     fail_count;
  int     pending;

  int extremes[7] = '{-32768, -32767, -1, 0, 1, 32766, 32767};

  segment_box_intersect_test #(.COORD_BITS(CB)) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_seg_start_x (in_seg_start_x),
    .in_seg_start_y (in_seg_start_y),
    .in_seg_end_x   (in_seg_end_x),
    .in_seg_end_y   (in_seg_end_y),
    .in_box_low_x   (in_box_low_x),
    .in_box_low_y   (in_box_low_y),
    .in_box_high_x  (in_box_high_x),
    .in_box_high_y  (in_box_high_y),
    .out_valid      (out_valid),
    .out_hit        (out_hit)
  );

  segment_box_checker #(.COORD_BITS(CB)) i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_seg_start_x (in_seg_start_x),
    .in_seg_start_y (in_seg_start_y),
    .in_seg_end_x   (in_seg_end_x),
    .in_seg_end_y   (in_seg_end_y),
    .in_box_low_x   (in_box_low_x),
    .in_box_low_y   (in_box_low_y),
    .in_box_high_x  (in_box_high_x),
    .in_box_high_y  (in_box_high_y),
    .out_valid      (out_valid),
    .out_hit        (out_hit),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs or drops results.
  initial begin
    #500000;
    $display("FAILED: results differ");
    $finish;
  end

  // Wrap an int into the coordinate width; overflow simply wraps.
  function automatic coord_t fit(int v);
    return v[CB-1:0];
  endfunction

  // Small grid value in -6..6, dense in touching and collinear cases.
  function automatic int grid();
    return int'($urandom_range(12)) - 6;
  endfunction

  // Drive one transaction at this edge and hold it until the block takes it.
  task automatic issue(input int sx, input int sy,
                       input int ex, input int ey,
                       input int lx, input int ly,
                       input int hx, input int hy);
    in_seg_start_x <= fit(sx);
    in_seg_start_y <= fit(sy);
    in_seg_end_x   <= fit(ex);
    in_seg_end_y   <= fit(ey);
    in_box_low_x   <= fit(lx);
    in_box_low_y   <= fit(ly);
    in_box_high_x  <= fit(hx);
    in_box_high_y  <= fit(hy);
    start          <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Drop start for the given number of cycles.
  task automatic hold_off(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Drop start and wait until every outstanding result has come back.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // One random transaction; the mode mix favors boxes and segments that
  // sit close together so all four side tests get exercised.
  task automatic random_item();
    int mode;
    int sx, sy, ex, ey, lx, ly, hx, hy;
    int cx, cy, w, h, t, line;
    mode = $urandom_range(99);
    if (mode < 20) begin
      // Unrestricted: every bit of every field toggles.
      sx = $urandom; sy = $urandom; ex = $urandom; ey = $urandom;
      lx = $urandom; ly = $urandom; hx = $urandom; hy = $urandom;
    end else if (mode < 50) begin
      sx = grid(); sy = grid(); ex = grid(); ey = grid();
      lx = grid(); ly = grid(); hx = grid(); hy = grid();
      // Mostly ordered boxes; leave some unordered on purpose.
      if ($urandom_range(99) < 80) begin
        if (lx > hx) begin t = lx; lx = hx; hx = t; end
        if (ly > hy) begin t = ly; ly = hy; hy = t; end
      end
    end else if (mode < 75) begin
      // Medium box around a random center, segment ends nearby.
      cx = int'($urandom_range(60000)) - 30000;
      cy = int'($urandom_range(60000)) - 30000;
      w  = $urandom_range(1, 2000);
      h  = $urandom_range(1, 2000);
      lx = cx - w; hx = cx + w; ly = cy - h; hy = cy + h;
      sx = cx + int'($urandom_range(6 * w)) - 3 * w;
      ex = cx + int'($urandom_range(6 * w)) - 3 * w;
      sy = cy + int'($urandom_range(6 * h)) - 3 * h;
      ey = cy + int'($urandom_range(6 * h)) - 3 * h;
    end else if (mode < 90) begin
      // Segment lying on the line of one box side.
      lx = grid(); ly = grid(); hx = grid(); hy = grid();
      if (lx > hx) begin t = lx; lx = hx; hx = t; end
      if (ly > hy) begin t = ly; ly = hy; hy = t; end
      sx = grid(); sy = grid(); ex = grid(); ey = grid();
      case ($urandom_range(3))
        0: begin sy = ly; ey = ly; end
        1: begin sy = hy; ey = hy; end
        2: begin sx = lx; ex = lx; end
        default: begin sx = hx; ex = hx; end
      endcase
      line = $urandom_range(3);
      if (line == 0) begin
        // Collapse to a point segment now and then.
        ex = sx; ey = sy;
      end
    end else begin
      sx = extremes[3'($urandom_range(6))]; sy = extremes[3'($urandom_range(6))];
      ex = extremes[3'($urandom_range(6))]; ey = extremes[3'($urandom_range(6))];
      lx = extremes[3'($urandom_range(6))]; ly = extremes[3'($urandom_range(6))];
      hx = extremes[3'($urandom_range(6))]; hy = extremes[3'($urandom_range(6))];
    end
    issue(sx, sy, ex, ey, lx, ly, hx, hy);
  endtask

  initial begin
    // Hold every input at a known value before the first edge.
    rst_n          = 1'b0;
    start          = 1'b0;
    in_seg_start_x = '0;
    in_seg_start_y = '0;
    in_seg_end_x   = '0;
    in_seg_end_y   = '0;
    in_box_low_x   = '0;
    in_box_low_y   = '0;
    in_box_high_x  = '0;
    in_box_high_y  = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: extremes, the early reject, endpoint inside,
    // side crossings, corner touch and miss, collinear sides,
    // point segments and unordered boxes.
    issue(-32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767);
    issue(32767, 32767, 32767, 32767, -32768, -32768, 32767, 32767);
    issue(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
    issue(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
    issue(32767, -32768, -32768, 32767, 0, 0, 0, 0);
    issue(-32768, 0, 32767, 0, -10, -10, 10, 10);
    issue(20, 0, 30, 5, -10, -10, 10, 10);
    issue(0, 0, 0, 0, -10, -10, 10, 10);
    issue(11, 11, 11, 11, -10, -10, 10, 10);
    issue(10, 3, 10, 3, -10, -10, 10, 10);
    issue(5, -20, 25, 0, -10, -10, 10, 10);
    issue(0, -20, 20, 0, -10, -10, 10, 10);
    issue(-20, -10, 20, -10, -10, -10, 10, 10);
    issue(-10, -30, -10, 30, -10, -10, 10, 10);
    issue(-30, 10, -11, 10, -10, -10, 10, 10);
    issue(11, -32768, 9, 32767, -10, -10, 10, 10);
    issue(-5, -5, 5, 5, 0, 0, 0, 0);
    issue(-5, 5, 5, -5, 0, 1, 0, 1);
    issue(0, 0, 0, 0, 10, 10, -10, -10);
    issue(-20, 0, 20, 0, 10, -10, -10, 10);
    issue(0, -20, 0, 20, -10, 10, 10, -10);
    issue(-32768, 32767, 32767, -32768, -1, -1, 1, 1);

    // Let the pipeline run dry once before the random part.
    drain();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if ((n < CALM_FIRST || n > CALM_LAST) && $urandom_range(99) < 2)
        hold_off($urandom_range(1, 6));
      random_item();
    end

    // Wait out the outstanding results and the pipeline registers.
    drain();
    repeat (4) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

[segment_box_intersect_test.f]
rtl/sbi_pkg.sv
rtl/sbi_sdiff.sv
rtl/sbi_edge.sv
rtl/segment_box_intersect_test.sv
verif/segment_box_checker.sv
verif/segment_box_intersect_test_test.sv
